@@ design/rgmp_pkg.sv @@
// ----------------------------------------------------------------------------
// rgmp_pkg
// Shared types, constants, the last-position helper and the luma function of the gray packer.
// ----------------------------------------------------------------------------
`default_nettype none

package rgmp_pkg;

   localparam int unsigned COORD_W   = 7;
   localparam int unsigned SIZE_W    = 8;
   localparam int unsigned PIXEL_W   = 16;
   localparam int unsigned NIBBLE_W  = 4;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 8;

   localparam logic [SIZE_W-1:0]  MAX_AREA_SIZE = 8'd128;
   localparam logic [COORD_W-1:0] MAX_LAST_POS  = 7'd127;
   localparam logic signed [8:0]  CIRCLE_CENTER = 9'sd64;
   localparam logic [16:0]        CIRCLE_R2     = 17'd4096;

   localparam logic [16:0] LUMA_R = 17'd77;
   localparam logic [16:0] LUMA_G = 17'd151;
   localparam logic [16:0] LUMA_B = 17'd28;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AREA_LEFT   = 2'd0,
      CSR_AREA_TOP    = 2'd1,
      CSR_AREA_WIDTH  = 2'd2,
      CSR_AREA_HEIGHT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [SIZE_W-1:0]  width;
      logic [SIZE_W-1:0]  height;
   } area_cfg_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [COORD_W:0]   pos_x;
      logic [COORD_W:0]   pos_y;
      logic               area_end;
   } pixel_beat_type;

   function automatic logic [COORD_W-1:0] last_pos(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] dec;
      dec = size - 8'd1;
      if (size == '0 || size > MAX_AREA_SIZE) begin
         return MAX_LAST_POS;
      end
      return dec[COORD_W-1:0];
   endfunction

   function automatic logic [NIBBLE_W-1:0] gray_of(input logic [PIXEL_W-1:0] c);
      logic [16:0] r8;
      logic [16:0] g8;
      logic [16:0] b8;
      logic [16:0] luma;
      r8   = {9'd0, c[15:11], 3'd0};
      g8   = {9'd0, c[10:5], 2'd0};
      b8   = {9'd0, c[4:0], 3'd0};
      luma = r8 * LUMA_R + g8 * LUMA_G + b8 * LUMA_B;
      return luma[15:12];
   endfunction

endpackage

`default_nettype wire

@@ design/rgmp_tracker.sv @@
// ----------------------------------------------------------------------------
// rgmp_tracker
// Input register with column and row tracking inside the screen area.
// ----------------------------------------------------------------------------
`default_nettype none

module rgmp_tracker
   import rgmp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire area_cfg_type        area_cfg,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [PIXEL_W-1:0]  req_pixel_rgb565,
   input  wire logic                beat_take,
   output logic                     beat_valid,
   output pixel_beat_type           beat
);

   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic               valid_ff, valid_in;
   pixel_beat_type     beat_ff, beat_in;
   logic               accept;
   logic               row_end;
   logic               area_end;

   assign req_ready = !valid_ff || beat_take;
   assign accept    = req_valid && req_ready;
   assign row_end   = col_ff >= last_pos(area_cfg.width);
   assign area_end  = row_end && (row_ff >= last_pos(area_cfg.height));

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (beat_take) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in         = 1'b1;
         beat_in.pixel    = req_pixel_rgb565;
         beat_in.pos_x    = {1'b0, area_cfg.left} + {1'b0, col_ff};
         beat_in.pos_y    = {1'b0, area_cfg.top} + {1'b0, row_ff};
         beat_in.area_end = area_end;
         if (area_end) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + 7'd1;
         end else begin
            col_in = col_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

   area_restart_a: assert property (@(posedge clock) disable iff (reset)
      accept && area_end |=> col_ff == '0 && row_ff == '0)
      else $error("counters did not restart after the area end");

   take_needs_valid_a: assert property (@(posedge clock) disable iff (reset)
      beat_take |-> valid_ff)
      else $error("beat taken from an empty input register");

   row_wrap_a: assert property (@(posedge clock) disable iff (reset)
      accept && row_end && !area_end |=> col_ff == '0 && row_ff == $past(row_ff) + 7'd1)
      else $error("row end did not advance the row");

endmodule

`default_nettype wire

@@ design/rgmp_packer.sv @@
// ----------------------------------------------------------------------------
// rgmp_packer
// Circle mask, luma reduction and nibble pairing into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgmp_packer
   import rgmp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                beat_valid,
   input  wire pixel_beat_type      beat,
   output logic                     beat_take,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [BYTE_W-1:0]        rsp_packed_byte,
   output logic                     rsp_area_done
);

   logic                signed [8:0] dx, dy;
   logic [7:0]          mag_x, mag_y;
   logic [15:0]         sq_x, sq_y;
   logic [16:0]         dist2;
   logic                in_circle;
   logic [NIBBLE_W-1:0] gray;
   logic                emits;
   logic                out_free;

   logic                pending_ff, pending_in;
   logic [NIBBLE_W-1:0] held_ff, held_in;
   logic                valid_ff, valid_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic                done_ff, done_in;

   // circle mask on the unclipped screen position
   always_comb begin
      dx        = $signed({1'b0, beat.pos_x}) - CIRCLE_CENTER;
      dy        = $signed({1'b0, beat.pos_y}) - CIRCLE_CENTER;
      mag_x     = dx[8] ? 8'(-dx) : dx[7:0];
      mag_y     = dy[8] ? 8'(-dy) : dy[7:0];
      sq_x      = mag_x * mag_x;
      sq_y      = mag_y * mag_y;
      dist2     = {1'b0, sq_x} + {1'b0, sq_y};
      in_circle = dist2 <= CIRCLE_R2;
      gray      = in_circle ? gray_of(beat.pixel) : '0;
   end

   assign emits     = pending_ff || beat.area_end;
   assign out_free  = !valid_ff || rsp_ready;
   assign beat_take = beat_valid && (out_free || !emits);

   always_comb begin
      pending_in = pending_ff;
      held_in    = held_ff;
      valid_in   = valid_ff;
      byte_in    = byte_ff;
      done_in    = done_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (beat_take) begin
         if (pending_ff) begin
            valid_in   = 1'b1;
            byte_in    = {held_ff, gray};
            done_in    = beat.area_end;
            pending_in = 1'b0;
         end else if (beat.area_end) begin
            valid_in = 1'b1;
            byte_in  = {gray, 4'd0};
            done_in  = 1'b1;
         end else begin
            held_in    = gray;
            pending_in = 1'b1;
         end
         if (beat.area_end) begin
            pending_in = 1'b0;
            held_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         held_ff    <= '0;
         valid_ff   <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         held_ff    <= held_in;
         valid_ff   <= valid_in;
      end
      byte_ff <= byte_in;
      done_ff <= done_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_packed_byte = byte_ff;
   assign rsp_area_done   = done_ff;

   pair_closes_a: assert property (@(posedge clock) disable iff (reset)
      beat_take && pending_ff |=> !pending_ff && valid_ff)
      else $error("second pixel of a pair did not close the byte");

   pair_opens_a: assert property (@(posedge clock) disable iff (reset)
      beat_take && !pending_ff && !beat.area_end |=> pending_ff)
      else $error("first pixel of a pair was not held");

   area_flush_a: assert property (@(posedge clock) disable iff (reset)
      beat_take && beat.area_end |=> !pending_ff && valid_ff && done_ff)
      else $error("area end did not flush the pending pixel");

   lone_pixel_a: assert property (@(posedge clock) disable iff (reset)
      beat_take && !pending_ff && beat.area_end |=> byte_ff[3:0] == 4'd0)
      else $error("lone final pixel has a nonzero low nibble");

endmodule

`default_nettype wire

@@ design/rgb565_to_gray4_masked_packer.sv @@
// ----------------------------------------------------------------------------
// rgb565_to_gray4_masked_packer
// RGB565 pixel stream to packed 4-bit gray bytes with a circular mask.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one RGB565 pixel per beat, row-major over the screen area
//   set by the csr registers (left, top, width, height). Pixels outside the
//   circle of radius 64 around (64,64) become black. Two gray nibbles go out
//   per rsp_* beat, first pixel high; rsp_area_done marks the last byte of
//   the area, where a lone pixel leaves a zero low nibble.
//   Throughput: one pixel per cycle while rsp_ready keeps the result register
//   free, one byte per pixel pair. A byte's second pixel passes through the
//   input register, then the result register, from which the byte is valid on rsp.
//   csr_* writes are taken every cycle and must only happen while idle.
//   Reset clears the counters, the held nibble and both valid flags; the
//   area returns to 0,0 with size 128x128.
//   When rsp_ready is low the result register holds; the input register
//   still drains pixels that only open a pair, then req_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb565_to_gray4_masked_packer
   import rgmp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DAT_W-1:0]  csr_data,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [PIXEL_W-1:0]    req_pixel_rgb565,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [BYTE_W-1:0]          rsp_packed_byte,
   output logic                       rsp_area_done
);

   area_cfg_type   cfg_ff, cfg_in;
   logic           beat_valid;
   logic           beat_take;
   pixel_beat_type beat;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_AREA_LEFT:   cfg_in.left   = csr_data[COORD_W-1:0];
            CSR_AREA_TOP:    cfg_in.top    = csr_data[COORD_W-1:0];
            CSR_AREA_WIDTH:  cfg_in.width  = csr_data;
            CSR_AREA_HEIGHT: cfg_in.height = csr_data;
            default:         cfg_in        = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left   <= '0;
         cfg_ff.top    <= '0;
         cfg_ff.width  <= MAX_AREA_SIZE;
         cfg_ff.height <= MAX_AREA_SIZE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rgmp_tracker u_tracker (
      .clock            (clock),
      .reset            (reset),
      .area_cfg         (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_rgb565 (req_pixel_rgb565),
      .beat_take        (beat_take),
      .beat_valid       (beat_valid),
      .beat             (beat)
   );

   rgmp_packer u_packer (
      .clock           (clock),
      .reset           (reset),
      .beat_valid      (beat_valid),
      .beat            (beat),
      .beat_take       (beat_take),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_area_done   (rsp_area_done)
   );

endmodule

`default_nettype wire

@@ dv/rgb565_to_gray4_masked_packer_tb.sv @@
// ----------------------------------------------------------------------------
// rgb565_to_gray4_masked_packer_tb
// Self-checking bench for the masked RGB565 to 4-bit gray byte packer.
// Pixels are streamed over a series of screen areas set through the csr port.
// A bench-side copy of the counters, mask and luma math predicts each packed
// byte and its area flag. Every output beat is checked against the oldest
// prediction. Both sides add random idle cycles, and the output side stalls
// for long stretches so that the block backs up.
// ----------------------------------------------------------------------------

module rgb565_to_gray4_masked_packer_tb;
   import rgmp_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 4;
   localparam int RANDOM_PIXELS = 1450;

   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              done;
   } gray_byte_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   csr_index_type        csr_index = CSR_AREA_LEFT;
   logic [CSR_DAT_W-1:0] csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PIXEL_W-1:0]   req_pixel_rgb565 = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [BYTE_W-1:0]    rsp_packed_byte;
   logic                 rsp_area_done;

   // bench copy of the area registers and packer state
   logic [COORD_W-1:0]   cfg_left = '0;
   logic [COORD_W-1:0]   cfg_top = '0;
   logic [SIZE_W-1:0]    cfg_width = 8'd128;
   logic [SIZE_W-1:0]    cfg_height = 8'd128;
   logic [COORD_W-1:0]   col_pos = '0;
   logic [COORD_W-1:0]   row_pos = '0;
   logic [NIBBLE_W-1:0]  held_gray = '0;
   logic                 pair_open = 1'b0;

   logic [PIXEL_W-1:0]   pixel_q[$];
   gray_byte_t           expected_bytes[$];

   int n_queued = 0;
   int n_taken = 0;
   int n_bytes = 0;
   int n_areas = 0;
   int n_masked = 0;
   int n_csr = 0;
   int n_midarea = 0;
   int errors = 0;
   int req_wait = 0;
   int rsp_wait = 0;
   int hold_left = 0;
   int holds_done = 0;
   int quiet_cycles = 0;
   bit calm_req = 1'b0;
   bit calm_rsp = 1'b0;

   rgb565_to_gray4_masked_packer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_rgb565 (req_pixel_rgb565),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_packed_byte  (rsp_packed_byte),
      .rsp_area_done    (rsp_area_done)
   );

   always #5 clock = ~clock;

   function automatic logic [COORD_W-1:0] last_index(input logic [SIZE_W-1:0] size);
      if (size == '0 || size > 8'd128) begin
         return 7'd127;
      end
      return 7'(size - 8'd1);
   endfunction

   function automatic bit in_disc(input int x, input int y);
      int dx;
      int dy;
      dx = x - 64;
      dy = y - 64;
      return (dx * dx + dy * dy) <= 64 * 64;
   endfunction

   function automatic logic [NIBBLE_W-1:0] luma4(input logic [PIXEL_W-1:0] c);
      int unsigned red;
      int unsigned grn;
      int unsigned blu;
      int unsigned y;
      red = int'(c[15:11]) * 8;
      grn = int'(c[10:5]) * 4;
      blu = int'(c[4:0]) * 8;
      y = (77 * red + 151 * grn + 28 * blu) >> 8;
      return 4'(y >> 4);
   endfunction

   function automatic void pack_pixel(input logic [PIXEL_W-1:0] px);
      logic               row_end;
      logic               area_end;
      logic [PIXEL_W-1:0] shown;
      logic [NIBBLE_W-1:0] g;
      row_end = col_pos >= last_index(cfg_width);
      area_end = row_end && (row_pos >= last_index(cfg_height));
      shown = px;
      if (!in_disc(int'(cfg_left) + int'(col_pos), int'(cfg_top) + int'(row_pos))) begin
         shown = '0;
         n_masked++;
      end
      g = luma4(shown);
      if (pair_open) begin
         expected_bytes.push_back('{value: {held_gray, g}, done: area_end});
         pair_open = 1'b0;
      end else if (area_end) begin
         expected_bytes.push_back('{value: {g, 4'h0}, done: 1'b1});
      end else begin
         held_gray = g;
         pair_open = 1'b1;
      end
      if (area_end) begin
         col_pos = '0;
         row_pos = '0;
         pair_open = 1'b0;
         held_gray = '0;
         n_areas++;
      end else if (row_end) begin
         col_pos = '0;
         row_pos = row_pos + 7'd1;
      end else begin
         col_pos = col_pos + 7'd1;
      end
   endfunction

   function automatic int pixels_to_area_end();
      int col;
      int row;
      int lw;
      int lh;
      int n;
      col = col_pos;
      row = row_pos;
      lw = last_index(cfg_width);
      lh = last_index(cfg_height);
      n = 1;
      while (!(col >= lw && row >= lh)) begin
         if (col >= lw) begin
            col = 0;
            row = (row + 1) % 128;
         end else begin
            col++;
         end
         n++;
      end
      return n;
   endfunction

   // pixel driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            pack_pixel(req_pixel_rgb565);
            n_taken++;
         end
         if (!req_valid || req_ready) begin
            if (req_wait > 0) begin
               req_wait--;
               req_valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
               req_valid <= 1'b1;
               req_pixel_rgb565 <= pixel_q.pop_front();
               req_wait = calm_req ? 0 : $urandom_range(0, 4);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // byte monitor and output back-pressure
   always @(posedge clock) begin
      gray_byte_t exp_byte;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_bytes++;
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected beat, packed_byte %h area_done %b",
                        $time, rsp_packed_byte, rsp_area_done);
               errors++;
            end else begin
               exp_byte = expected_bytes.pop_front();
               if (rsp_packed_byte !== exp_byte.value) begin
                  $display("%0t: packed_byte expected %h got %h",
                           $time, exp_byte.value, rsp_packed_byte);
                  errors++;
               end
               if (rsp_area_done !== exp_byte.done) begin
                  $display("%0t: area_done expected %b got %b",
                           $time, exp_byte.done, rsp_area_done);
                  errors++;
               end
            end
            rsp_wait = calm_rsp ? 0 : $urandom_range(0, 4);
         end
         if (hold_left == 0 && holds_done < 2 && n_bytes > 40 && pixel_q.size() > 24) begin
            hold_left = 120;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d bytes still expected",
                     $time, quiet_cycles, expected_bytes.size());
            $display("[rgb565_to_gray4_masked_packer] ERROR");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      do @(negedge clock);
      while (!(n_taken == n_queued && expected_bytes.size() == 0));
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_put(input csr_index_type idx, input logic [CSR_DAT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         CSR_AREA_LEFT:   cfg_left = value[COORD_W-1:0];
         CSR_AREA_TOP:    cfg_top = value[COORD_W-1:0];
         CSR_AREA_WIDTH:  cfg_width = value;
         CSR_AREA_HEIGHT: cfg_height = value;
         default: ;
      endcase
      n_csr++;
   endtask

   task automatic write_area(input logic [CSR_DAT_W-1:0] l, input logic [CSR_DAT_W-1:0] t,
                             input logic [CSR_DAT_W-1:0] w, input logic [CSR_DAT_W-1:0] h);
      wait_drained();
      @(posedge clock);
      csr_put(CSR_AREA_LEFT, l);
      csr_put(CSR_AREA_TOP, t);
      csr_put(CSR_AREA_WIDTH, w);
      csr_put(CSR_AREA_HEIGHT, h);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic push_pixel(input logic [PIXEL_W-1:0] v);
      pixel_q.push_back(v);
      n_queued++;
   endtask

   task automatic push_random(input int n);
      logic [PIXEL_W-1:0] v;
      repeat (n) begin
         case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            2: v = 16'hF800;
            3: v = 16'h07E0;
            default: v = 16'($urandom);
         endcase
         push_pixel(v);
      end
   endtask

   initial begin
      int area_num;
      int w;
      int h;
      int part;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset-size area from the top-left corner, outside the disc
      push_pixel(16'h0000);
      push_pixel(16'hFFFF);
      push_pixel(16'hF800);
      push_pixel(16'h07E0);
      push_pixel(16'h001F);
      // shrink the area while a row is open
      write_area(8'd64, 8'd64, 8'd3, 8'd2);
      n_midarea++;
      push_random(pixels_to_area_end());
      // single pixel area, lone nibble
      write_area(8'd64, 8'd64, 8'd1, 8'd1);
      push_pixel(16'hFFFF);
      // top edge of the disc
      write_area(8'd64, 8'd0, 8'd3, 8'd1);
      repeat (3) push_pixel(16'hFFFF);
      // left edge of the disc
      write_area(8'd0, 8'd64, 8'd2, 8'd2);
      repeat (4) push_pixel(16'hFFFF);
      // far corner, offsets at their maximum
      write_area(8'hFF, 8'd127, 8'd2, 8'd1);
      repeat (2) push_pixel(16'hFFFF);

      area_num = 0;
      while (n_queued < RANDOM_PIXELS) begin
         calm_req = ($urandom_range(0, 3) == 0);
         calm_rsp = ($urandom_range(0, 3) == 0);
         if (area_num == 0 || $urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 4))
               0: begin w = 128; h = $urandom_range(1, 2); end
               1: begin w = 0; h = 1; end
               2: begin w = $urandom_range(129, 255); h = 1; end
               3: begin w = 1; h = 128; end
               default: begin w = 1; h = 0; end
            endcase
         end else begin
            w = $urandom_range(1, 16);
            h = $urandom_range(1, 6);
         end
         write_area(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'(w), 8'(h));
         if ($urandom_range(0, 7) == 0 && pixels_to_area_end() > 1) begin
            part = $urandom_range(1, pixels_to_area_end() - 1);
            push_random(part);
            write_area(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(1, 16)), 8'($urandom_range(1, 6)));
            n_midarea++;
         end
         push_random(pixels_to_area_end());
         area_num++;
      end

      wait_drained();
      $display("%0d pixels over %0d areas, %0d bytes checked, %0d pixels masked to black",
               n_taken, n_areas, n_bytes, n_masked);
      $display("%0d register writes, %0d areas resized while open, %0d long output stalls",
               n_csr, n_midarea, holds_done);
      if (errors == 0) begin
         $display("[rgb565_to_gray4_masked_packer] OK");
      end else begin
         $display("[rgb565_to_gray4_masked_packer] ERROR");
      end
      $finish;
   end

endmodule
